### hdl/sgmo_pkg.sv
// Shared types, constants and the arctangent table for the Sobel gradient
// magnitude and orientation block. No dependencies.

package sgmo_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int CORDIC_STEPS    = 20;
    localparam int HALF_PI_UNITS   = 32941987;
    localparam int ORIENT_MAX      = 16085;
    localparam int ORIENT_FLAT     = 8042;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 12;
    localparam int WIDTH_RESET     = 640;
    localparam int HEIGHT_RESET    = 480;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_GRAD,
        S_SQUARE,
        S_CALC,
        S_FINISH,
        S_OUT
    } state_t;

    // Slot code: bit 1 selects the lower row of the run, bit 0 the last-column result.
    typedef struct packed {
        logic       accept;
        logic       load;
        logic       grad;
        logic       square;
        logic       step;
        logic       finish;
        logic [1:0] slot;
        logic [4:0] iter;
    } cmd_t;

    typedef struct packed {
        logic [3:0] slot_valid;
        logic       last_row;
        logic       last_col;
    } status_t;

    function automatic logic signed [27:0] atan_units(input logic [4:0] i);
        logic signed [27:0] v;
        case (i)
            5'd0:    v = 28'sd16470993;
            5'd1:    v = 28'sd9723395;
            5'd2:    v = 28'sd5137575;
            5'd3:    v = 28'sd2607913;
            5'd4:    v = 28'sd1309017;
            5'd5:    v = 28'sd655147;
            5'd6:    v = 28'sd327653;
            5'd7:    v = 28'sd163837;
            5'd8:    v = 28'sd81920;
            5'd9:    v = 28'sd40960;
            5'd10:   v = 28'sd20480;
            5'd11:   v = 28'sd10240;
            5'd12:   v = 28'sd5120;
            5'd13:   v = 28'sd2560;
            5'd14:   v = 28'sd1280;
            5'd15:   v = 28'sd640;
            5'd16:   v = 28'sd320;
            5'd17:   v = 28'sd160;
            5'd18:   v = 28'sd80;
            5'd19:   v = 28'sd40;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/sgmo_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.

module sgmo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### hdl/sgmo_datapath.sv
// Datapath: configuration, raster counters, gray conversion, line stores,
// 3x3 window, Sobel gradients, iterative square root and CORDIC.
// Depends on sgmo_pkg and sgmo_ram.

module sgmo_datapath #(
    parameter int MAX_WIDTH = sgmo_pkg::MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sgmo_pkg::cmd_t                     cmd,
    output sgmo_pkg::status_t                  status,
    input  logic [23:0]                        bgr_pixel,
    input  logic                               cfg_wr,
    input  logic [sgmo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sgmo_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [14:0]                        magnitude,
    output logic [13:0]                        orientation,
    output logic [11:0]                        out_row,
    output logic [CW-1:0]                      out_col
);

    logic [10:0]        width_reg;
    logic [11:0]        height_reg;
    logic [CW-1:0]      col_cnt_reg;
    logic [11:0]        row_cnt_reg;
    logic [CW-1:0]      c_snap_reg;
    logic [11:0]        r_snap_reg;
    logic               lc_snap_reg;
    logic               lr_snap_reg;
    logic [23:0]        pix_reg;
    logic [7:0]         win_reg [9];

    logic [31:0]        w_raw;
    logic [31:0]        w_sat;
    logic [11:0]        h_sat;
    logic               last_col_now;
    logic               last_row_now;
    logic [21:0]        gray_sum;
    logic [7:0]         gray;
    logic [CW-1:0]      ram_addr;
    logic [7:0]         older_rd;
    logic [7:0]         newer_rd;

    logic [7:0]         vt [3];
    logic [7:0]         vm [3];
    logic [7:0]         vb [3];
    logic [1:0]         li;
    logic [1:0]         ci;
    logic [1:0]         ri;
    logic [11:0]        sum_r;
    logic [11:0]        sum_l;
    logic [11:0]        gy_u;
    logic signed [11:0] gx_reg;
    logic signed [11:0] gy_reg;

    logic signed [23:0] gxe;
    logic signed [23:0] gye;
    logic [23:0]        sqx;
    logic [23:0]        sqy;
    logic [23:0]        sq_sum;
    logic [11:0]        ax;

    logic [31:0]        rem_reg;
    logic [31:0]        res_reg;
    logic [31:0]        bit_reg;
    logic signed [29:0] x_reg;
    logic signed [29:0] y_reg;
    logic signed [27:0] z_reg;
    logic signed [29:0] xs;
    logic signed [29:0] ys;
    logic signed [27:0] at;
    logic [31:0]        trial;

    logic signed [27:0] ang;
    logic [27:0]        ang_pos;
    logic [27:0]        q;
    logic [13:0]        ori_next;
    logic [14:0]        mag_reg;
    logic [13:0]        ori_reg;
    logic [11:0]        row_out_reg;
    logic [CW-1:0]      col_out_reg;

    // Frame geometry with saturation
    always_comb
    begin
        w_raw = 32'(width_reg);
        if (w_raw < 32'd3)
        begin
            w_sat = 32'd3;
        end
        else if (w_raw > 32'(MAX_WIDTH))
        begin
            w_sat = 32'(MAX_WIDTH);
        end
        else
        begin
            w_sat = w_raw;
        end
        h_sat        = (height_reg < 12'd3) ? 12'd3 : height_reg;
        last_col_now = 32'(col_cnt_reg) >= (w_sat - 32'd1);
        last_row_now = row_cnt_reg >= (h_sat - 12'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'(sgmo_pkg::WIDTH_RESET);
            height_reg <= 12'(sgmo_pkg::HEIGHT_RESET);
        end
        else if (cfg_wr)
        begin
            if (cfg_index == sgmo_pkg::REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data[10:0];
            end
            else if (cfg_index == sgmo_pkg::REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            lc_snap_reg <= 1'b0;
            lr_snap_reg <= 1'b0;
            c_snap_reg  <= '0;
            r_snap_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            c_snap_reg  <= col_cnt_reg;
            r_snap_reg  <= row_cnt_reg;
            lc_snap_reg <= last_col_now;
            lr_snap_reg <= last_row_now;
            if (last_col_now)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= last_row_now ? 12'd0 : row_cnt_reg + 12'd1;
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg <= bgr_pixel;
        end
    end

    assign gray_sum = 22'(14'd1868 * pix_reg[7:0]) + 22'(14'd9617 * pix_reg[15:8])
                    + 22'(13'd4899 * pix_reg[23:16]) + 22'd8192;
    assign gray     = gray_sum[21:14];

    // Read at the live column while idle, write back at the captured column
    assign ram_addr = cmd.load ? c_snap_reg : col_cnt_reg;

    sgmo_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (cmd.load),
        .addr  (ram_addr),
        .wdata (newer_rd),
        .rdata (older_rd)
    );

    sgmo_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_newer (
        .clk   (clk),
        .we    (cmd.load),
        .addr  (ram_addr),
        .wdata (gray),
        .rdata (newer_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= 8'd0;
            end
        end
        else if (cmd.load)
        begin
            for (int v = 0; v < 3; v++)
            begin
                win_reg[v*3]   <= win_reg[v*3+1];
                win_reg[v*3+1] <= win_reg[v*3+2];
            end
            win_reg[2] <= older_rd;
            win_reg[5] <= newer_rd;
            win_reg[8] <= gray;
        end
    end

    // Column vectors with vertical and horizontal reflection at the frame edges
    always_comb
    begin
        for (int h = 0; h < 3; h++)
        begin
            if (!cmd.slot[1])
            begin
                vt[h] = (r_snap_reg == 12'd1) ? win_reg[6+h] : win_reg[h];
                vm[h] = win_reg[3+h];
                vb[h] = win_reg[6+h];
            end
            else
            begin
                vt[h] = win_reg[3+h];
                vm[h] = win_reg[6+h];
                vb[h] = win_reg[3+h];
            end
        end
        if (cmd.slot[0])
        begin
            li = 2'd1; ci = 2'd2; ri = 2'd1;
        end
        else if (c_snap_reg == CW'(1))
        begin
            li = 2'd2; ci = 2'd1; ri = 2'd2;
        end
        else
        begin
            li = 2'd0; ci = 2'd1; ri = 2'd2;
        end
        sum_r = 12'(vt[ri]) + {3'd0, vm[ri], 1'b0} + 12'(vb[ri]);
        sum_l = 12'(vt[li]) + {3'd0, vm[li], 1'b0} + 12'(vb[li]);
        gy_u  = (12'(vb[li]) - 12'(vt[li])) + ((12'(vb[ci]) - 12'(vt[ci])) << 1)
              + (12'(vb[ri]) - 12'(vt[ri]));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.grad)
        begin
            gx_reg      <= $signed(sum_r - sum_l);
            gy_reg      <= $signed(gy_u);
            row_out_reg <= cmd.slot[1] ? r_snap_reg : r_snap_reg - 12'd1;
            col_out_reg <= cmd.slot[0] ? c_snap_reg : c_snap_reg - CW'(1);
        end
    end

    assign gxe    = 24'(gx_reg);
    assign gye    = 24'(gy_reg);
    assign sqx    = gxe * gxe;
    assign sqy    = gye * gye;
    assign sq_sum = sqx + sqy;
    assign ax     = gx_reg[11] ? 12'(-gx_reg) : gx_reg;

    assign xs    = x_reg >>> cmd.iter;
    assign ys    = y_reg >>> cmd.iter;
    assign at    = sgmo_pkg::atan_units(cmd.iter);
    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            rem_reg <= {sq_sum, 8'd0};
            res_reg <= 32'd0;
            bit_reg <= 32'h4000_0000;
            x_reg   <= 30'({ax, 16'd0});
            y_reg   <= 30'($signed({gy_reg, 16'd0}));
            z_reg   <= 28'sd0;
        end
        else if (cmd.step)
        begin
            if (bit_reg != 32'd0)
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            if (!y_reg[29])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
        end
    end

    // Angle back to 0..pi, round, clamp; vertical gradient handled apart
    always_comb
    begin
        ang     = 28'(sgmo_pkg::HALF_PI_UNITS) + (gx_reg[11] ? -z_reg : z_reg);
        ang_pos = ang[27] ? 28'd0 : ang;
        q       = (ang_pos + 28'd2048) >> 12;
        if (gx_reg == 12'sd0)
        begin
            if (gy_reg > 12'sd0)
            begin
                ori_next = 14'(sgmo_pkg::ORIENT_MAX);
            end
            else if (gy_reg < 12'sd0)
            begin
                ori_next = 14'd0;
            end
            else
            begin
                ori_next = 14'(sgmo_pkg::ORIENT_FLAT);
            end
        end
        else if (q > 28'(sgmo_pkg::ORIENT_MAX))
        begin
            ori_next = 14'(sgmo_pkg::ORIENT_MAX);
        end
        else
        begin
            ori_next = q[13:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            mag_reg <= 15'(res_reg + 32'(rem_reg > res_reg));
            ori_reg <= ori_next;
        end
    end

    always_comb
    begin
        status.slot_valid[0] = (r_snap_reg != 12'd0) && (c_snap_reg != CW'(0));
        status.slot_valid[1] = (r_snap_reg != 12'd0) && lc_snap_reg;
        status.slot_valid[2] = status.slot_valid[0] && lr_snap_reg;
        status.slot_valid[3] = status.slot_valid[1] && lr_snap_reg;
        status.last_row      = lr_snap_reg;
        status.last_col      = lc_snap_reg;
    end

    assign magnitude   = mag_reg;
    assign orientation = ori_reg;
    assign out_row     = row_out_reg;
    assign out_col     = col_out_reg;

endmodule

### hdl/sgmo_ctrl.sv
// Controller: sequences pixel load, result slots and the shared
// square-root / CORDIC iterations. Depends on sgmo_pkg.

module sgmo_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              last_of_run,
    output logic              end_of_frame,
    output sgmo_pkg::cmd_t    cmd,
    input  sgmo_pkg::status_t status
);

    sgmo_pkg::state_t state_reg;
    sgmo_pkg::state_t state_next;
    logic [1:0]       slot_reg;
    logic [1:0]       slot_next;
    logic [4:0]       iter_reg;
    logic [4:0]       iter_next;
    logic [3:0]       later_mask;
    logic [3:0]       later;
    logic [1:0]       first_slot;
    logic [1:0]       next_slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgmo_pkg::S_IDLE;
            slot_reg  <= 2'd0;
            iter_reg  <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            iter_reg  <= iter_next;
        end
    end

    // Find first slot and the next slot after the current one
    always_comb
    begin
        first_slot = 2'd0;
        next_slot  = 2'd0;
        for (int s = 3; s >= 0; s--)
        begin
            later_mask[s] = (2'(s) > slot_reg);
            if (status.slot_valid[s])
            begin
                first_slot = 2'(s);
            end
            if (status.slot_valid[s] && (2'(s) > slot_reg))
            begin
                next_slot = 2'(s);
            end
        end
        later = status.slot_valid & later_mask;
    end

    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        iter_next    = iter_reg;
        cmd          = '0;
        cmd.slot     = slot_reg;
        cmd.iter     = iter_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        last_of_run  = (later == 4'd0);
        end_of_frame = (later == 4'd0) && status.last_row && status.last_col;
        case (state_reg)
            sgmo_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sgmo_pkg::S_LOAD;
                end
            end
            sgmo_pkg::S_LOAD:
            begin
                cmd.load = 1'b1;
                if (status.slot_valid != 4'd0)
                begin
                    slot_next  = first_slot;
                    state_next = sgmo_pkg::S_GRAD;
                end
                else
                begin
                    state_next = sgmo_pkg::S_IDLE;
                end
            end
            sgmo_pkg::S_GRAD:
            begin
                cmd.grad   = 1'b1;
                state_next = sgmo_pkg::S_SQUARE;
            end
            sgmo_pkg::S_SQUARE:
            begin
                cmd.square = 1'b1;
                iter_next  = 5'd0;
                state_next = sgmo_pkg::S_CALC;
            end
            sgmo_pkg::S_CALC:
            begin
                cmd.step = 1'b1;
                if (iter_reg == 5'(sgmo_pkg::CORDIC_STEPS - 1))
                begin
                    iter_next  = 5'd0;
                    state_next = sgmo_pkg::S_FINISH;
                end
                else
                begin
                    iter_next = iter_reg + 5'd1;
                end
            end
            sgmo_pkg::S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = sgmo_pkg::S_OUT;
            end
            sgmo_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (later != 4'd0)
                    begin
                        slot_next  = next_slot;
                        state_next = sgmo_pkg::S_GRAD;
                    end
                    else
                    begin
                        state_next = sgmo_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sgmo_pkg::S_IDLE;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        iter_reg < 5'(sgmo_pkg::CORDIC_STEPS))
        else $error("iteration count out of range");

    a_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status.slot_valid[slot_reg])
        else $error("result presented for an empty slot");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_frame) |-> last_of_run)
        else $error("frame end not on last result of run");

    a_load_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == sgmo_pkg::S_LOAD))
        else $error("line store update skipped");

endmodule

### hdl/sobel_gradient_magnitude_orientation.sv
// Top level: Sobel gradient magnitude and orientation over a BGR raster stream.
// Depends on sgmo_pkg, sgmo_ctrl, sgmo_datapath (and sgmo_ram below it).
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | bgr_pixel[23:0]
//  out     | out_valid/ out_ready | magnitude, orientation, out_row, out_col,
//          |                      | last_of_run, end_of_frame
//  cfg     | cfg_valid/ cfg_ready | cfg_index (0 width, 1 height), cfg_data
//
// A pixel goes through accept and line store read/write, then for each result
// it yields (0 to 4): gradient, squares, 20 shared square-root/CORDIC
// iterations, rounding, presentation. One pixel is in flight at a time; a new
// pixel is taken once every result of the previous one has been accepted.
// Reset clears counters, window, configuration and control state; the
// arithmetic and output registers and line store contents are undefined
// until written. cfg_ready is always high.

module sobel_gradient_magnitude_orientation #(
    parameter int MAX_WIDTH = sgmo_pkg::MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [23:0]                     bgr_pixel,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [14:0]                     magnitude,
    output logic [13:0]                     orientation,
    output logic [11:0]                     out_row,
    output logic [CW-1:0]                   out_col,
    output logic                            last_of_run,
    output logic                            end_of_frame,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sgmo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgmo_pkg::CFG_DATA_W-1:0] cfg_data
);

    sgmo_pkg::cmd_t    cmd;
    sgmo_pkg::status_t status;

    assign cfg_ready = 1'b1;

    sgmo_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame),
        .cmd          (cmd),
        .status       (status)
    );

    sgmo_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .bgr_pixel   (bgr_pixel),
        .cfg_wr      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .magnitude   (magnitude),
        .orientation (orientation),
        .out_row     (out_row),
        .out_col     (out_col)
    );

endmodule

### test/tb.sv
// Testbench for sobel_gradient_magnitude_orientation: random and directed BGR frames,
// an in-bench gray/Sobel/CORDIC predictor and an in-order result checker.
// Depends on sgmo_pkg and the RTL top level.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH = sgmo_pkg::MAX_WIDTH_DEF;

    typedef struct {
        logic [14:0] mag;
        logic [13:0] ang;
        logic [11:0] row;
        logic [9:0]  col;
        logic        run_end;
        logic        frame_end;
    } grad_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [23:0] bgr_pixel = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [14:0] magnitude;
    logic [13:0] orientation;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        last_of_run;
    logic        end_of_frame;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [sgmo_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sgmo_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic [7:0] older_px [LINE_DEPTH];
    logic [7:0] newer_px [LINE_DEPTH];
    int         win [9];
    int         col_pos;
    int         row_pos;
    int         width_reg;
    int         height_reg;
    grad_t      pending_grad [$];

    int  mismatches = 0;
    int  pixels_sent = 0;
    int  grads_seen = 0;
    bit  idling = 1'b1;
    bit  out_hold = 1'b0;
    event hold_go;

    sobel_gradient_magnitude_orientation dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .bgr_pixel(bgr_pixel),
        .out_valid(out_valid), .out_ready(out_ready),
        .magnitude(magnitude), .orientation(orientation),
        .out_row(out_row), .out_col(out_col),
        .last_of_run(last_of_run), .end_of_frame(end_of_frame),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int unsigned int_sqrt(input int unsigned n);
        int unsigned res;
        int unsigned bitv;
        res = 0;
        bitv = 32'h4000_0000;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [14:0] grad_magnitude(input int gx, input int gy);
        int unsigned t;
        int unsigned f;
        t = 256 * (gx * gx + gy * gy);
        f = int_sqrt(t);
        if (t - f * f > f)
            f++;
        return f[14:0];
    endfunction

    function automatic logic [13:0] grad_angle(input int gx, input int gy);
        longint x;
        longint y;
        longint z;
        longint a;
        longint q;
        longint xs;
        longint ys;
        if (gx == 0)
            return gy > 0 ? 14'(sgmo_pkg::ORIENT_MAX)
                          : (gy < 0 ? 14'd0 : 14'(sgmo_pkg::ORIENT_FLAT));
        x = longint'(gx < 0 ? -gx : gx) * 65536;
        y = longint'(gy) * 65536;
        z = 0;
        for (int i = 0; i < sgmo_pkg::CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += sgmo_pkg::atan_units(5'(i));
            end
            else
            begin
                x -= ys; y += xs; z -= sgmo_pkg::atan_units(5'(i));
            end
        end
        a = sgmo_pkg::HALF_PI_UNITS + (gx > 0 ? z : -z);
        if (a < 0)
            a = 0;
        q = (a + 2048) >>> 12;
        if (q > sgmo_pkg::ORIENT_MAX)
            q = sgmo_pkg::ORIENT_MAX;
        return q[13:0];
    endfunction

    // columns are {top, middle, bottom}
    function automatic void push_grad(input int l0, l1, l2, c0, c2, r0, r1, r2,
                                      input int row, input int col);
        grad_t g;
        int gx;
        int gy;
        gx = (r0 + 2 * r1 + r2) - (l0 + 2 * l1 + l2);
        gy = (l2 - l0) + 2 * (c2 - c0) + (r2 - r0);
        g.mag = grad_magnitude(gx, gy);
        g.ang = grad_angle(gx, gy);
        g.row = row[11:0];
        g.col = col[9:0];
        g.run_end = 1'b0;
        g.frame_end = 1'b0;
        pending_grad.push_back(g);
    endfunction

    // v[column][vertical]
    function automatic void push_row(input int v [3][3], input int row, input int c,
                                     input bit last_col);
        if (c == 1)
            push_grad(v[2][0], v[2][1], v[2][2], v[1][0], v[1][2],
                      v[2][0], v[2][1], v[2][2], row, 0);
        else if (c >= 2)
            push_grad(v[0][0], v[0][1], v[0][2], v[1][0], v[1][2],
                      v[2][0], v[2][1], v[2][2], row, c - 1);
        if (last_col)
            push_grad(v[1][0], v[1][1], v[1][2], v[2][0], v[2][2],
                      v[1][0], v[1][1], v[1][2], row, c);
    endfunction

    function automatic void predict_pixel(input logic [23:0] px);
        int w;
        int h;
        int gray;
        int idx;
        int queued;
        int v [3][3];
        bit last_col;
        bit last_row;
        w = width_reg < 3 ? 3 : (width_reg > LINE_DEPTH ? LINE_DEPTH : width_reg);
        h = height_reg < 3 ? 3 : height_reg;
        gray = (1868 * px[7:0] + 9617 * px[15:8] + 4899 * px[23:16] + 8192) >> 14;
        idx = col_pos < LINE_DEPTH ? col_pos : LINE_DEPTH - 1;
        last_col = col_pos >= w - 1;
        last_row = row_pos >= h - 1;
        queued = pending_grad.size();
        for (int i = 0; i < 3; i++)
        begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = older_px[idx];
        win[5] = newer_px[idx];
        win[8] = gray;
        older_px[idx] = newer_px[idx];
        newer_px[idx] = gray[7:0];
        if (row_pos >= 1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v[i][0] = row_pos == 1 ? win[6+i] : win[i];
                v[i][1] = win[3+i];
                v[i][2] = win[6+i];
            end
            push_row(v, row_pos - 1, col_pos, last_col);
            if (last_row)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    v[i][0] = win[3+i];
                    v[i][1] = win[6+i];
                    v[i][2] = win[3+i];
                end
                push_row(v, row_pos, col_pos, last_col);
            end
        end
        if (pending_grad.size() > queued)
        begin
            pending_grad[$].run_end = 1'b1;
            pending_grad[$].frame_end = last_row && last_col;
        end
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
            col_pos++;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: %s mismatch at grad %0d: got %0d, want %0d",
                 $realtime, what, grads_seen, got, want);
    endtask

    // long receiver stall, counted here
    always
    begin
        @(hold_go);
        out_hold <= 1'b1;
        repeat (400) @(posedge clk);
        out_hold <= 1'b0;
    end

    // result side: check each transaction, then pick the next ready level
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                grad_t g;
                if (pending_grad.size() == 0)
                    report_mismatch("result count", 1, 0);
                else
                begin
                    g = pending_grad.pop_front();
                    if (magnitude !== g.mag)
                        report_mismatch("magnitude", magnitude, g.mag);
                    if (orientation !== g.ang)
                        report_mismatch("orientation", orientation, g.ang);
                    if (out_row !== g.row)
                        report_mismatch("out_row", out_row, g.row);
                    if (out_col !== g.col)
                        report_mismatch("out_col", out_col, g.col);
                    if (last_of_run !== g.run_end)
                        report_mismatch("last_of_run", last_of_run, g.run_end);
                    if (end_of_frame !== g.frame_end)
                        report_mismatch("end_of_frame", end_of_frame, g.frame_end);
                end
                grads_seen++;
            end
            if (out_hold)
                out_ready <= 1'b0;
            else
                out_ready <= !(idling && $urandom_range(99) < 13);
        end
    end

    task automatic send_pixel(input logic [23:0] px);
        while (idling && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        bgr_pixel <= px;
        predict_pixel(px);
        pixels_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // drop valid and let every expected result drain
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_grad.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sgmo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sgmo_pkg::CFG_DATA_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == sgmo_pkg::REG_IMAGE_WIDTH)
            width_reg = val[10:0];
        else if (idx == sgmo_pkg::REG_IMAGE_HEIGHT)
            height_reg = val;
    endtask

    function automatic logic [23:0] random_pixel;
        case ($urandom_range(5))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic finish_frame;
        do
            send_pixel(random_pixel());
        while (col_pos != 0 || row_pos != 0);
    endtask

    // reset sizes, then shrink width and height mid-frame so the column counter is past the end
    task automatic test_reset_sizes;
        repeat (5) send_pixel(random_pixel());
        write_reg(sgmo_pkg::REG_IMAGE_WIDTH, 12'd3);
        write_reg(sgmo_pkg::REG_IMAGE_HEIGHT, 12'd3);
        finish_frame();
    endtask

    // below-range sizes saturate to 3; zero, full-scale, single- and two-channel pixels
    task automatic test_small_extremes;
        logic [23:0] pat [9] = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                                 24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'hFFFFFF};
        write_reg(sgmo_pkg::REG_IMAGE_WIDTH, 12'd2);
        write_reg(sgmo_pkg::REG_IMAGE_HEIGHT, 12'd0);
        foreach (pat[i])
            send_pixel(pat[i]);
    endtask

    task automatic test_width_shrink_midrow;
        write_reg(sgmo_pkg::REG_IMAGE_WIDTH, 12'd8);
        write_reg(sgmo_pkg::REG_IMAGE_HEIGHT, 12'd4);
        repeat (12) send_pixel(random_pixel());
        write_reg(sgmo_pkg::REG_IMAGE_WIDTH, 12'd3);
        finish_frame();
    endtask

    // over-range width saturates to the line length; shrink after a few pixels
    task automatic test_wide_frame;
        write_reg(sgmo_pkg::REG_IMAGE_WIDTH, 12'hFFF);
        write_reg(sgmo_pkg::REG_IMAGE_HEIGHT, 12'd3);
        repeat (8) send_pixel(random_pixel());
        write_reg(sgmo_pkg::REG_IMAGE_WIDTH, 12'd4);
        finish_frame();
    endtask

    // hold: no idling on either side through the whole tall frame
    task automatic test_tall_frame;
        write_reg(sgmo_pkg::REG_IMAGE_WIDTH, 12'd3);
        write_reg(sgmo_pkg::REG_IMAGE_HEIGHT, 12'd10);
        idling = 1'b0;
        finish_frame();
        drain();
        idling = 1'b1;
    endtask

    task automatic test_backpressure;
        write_reg(sgmo_pkg::REG_IMAGE_WIDTH, 12'd5);
        write_reg(sgmo_pkg::REG_IMAGE_HEIGHT, 12'd3);
        -> hold_go;
        finish_frame();
    endtask

    task automatic test_random_frames;
        int start;
        start = pixels_sent;
        while (pixels_sent - start < 20)
        begin
            write_reg(sgmo_pkg::REG_IMAGE_WIDTH, 12'($urandom_range(3, 6)));
            write_reg(sgmo_pkg::REG_IMAGE_HEIGHT, 12'($urandom_range(3, 4)));
            finish_frame();
        end
    endtask

    initial
    begin
        foreach (older_px[i])
        begin
            older_px[i] = '0;
            newer_px[i] = '0;
        end
        foreach (win[i])
            win[i] = 0;
        col_pos = 0;
        row_pos = 0;
        width_reg = sgmo_pkg::WIDTH_RESET;
        height_reg = sgmo_pkg::HEIGHT_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_sizes();
        test_small_extremes();
        test_width_shrink_midrow();
        test_backpressure();
        test_random_frames();
        test_wide_frame();
        test_tall_frame();
        drain();

        $display("Sent %0d pixels, checked %0d gradient results over small frames,",
                 pixels_sent, grads_seen);
        $display("saturated sizes, mid-row width shrinks, a long output stall and a gapless frame.");
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Timeout with %0d results outstanding", pending_grad.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
hdl/sgmo_pkg.sv
hdl/sgmo_ram.sv
hdl/sgmo_datapath.sv
hdl/sgmo_ctrl.sv
hdl/sobel_gradient_magnitude_orientation.sv
test/tb.sv
